/* hw/rtl/mfl_pkg.sv */
// ----------------------------------------------------------------------------
// mfl_pkg
// Shared constants, command codes, types and helpers for the monochrome
// frame buffer with row-wise flush to a memory-LCD panel.
// ----------------------------------------------------------------------------
package mfl_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 128;
  localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
  localparam int ROW_BITS     = ROW_BYTES * 8;
  localparam int ROW_AW       = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int SEQ_W        = $clog2(ROW_BYTES + 4);

  localparam logic [2:0] MODE_PIXEL     = 3'd0;
  localparam logic [2:0] MODE_HLINE     = 3'd1;
  localparam logic [2:0] MODE_VLINE     = 3'd2;
  localparam logic [2:0] MODE_RECT      = 3'd3;
  localparam logic [2:0] MODE_FLUSH_ROW = 3'd4;
  localparam logic [2:0] MODE_FLUSH_END = 3'd5;
  localparam logic [2:0] MODE_CLEAR     = 3'd6;

  localparam logic [7:0] BYTE_UPDATE  = 8'h80;
  localparam logic [7:0] BYTE_CLEAR   = 8'h20;
  localparam logic [7:0] BYTE_TRAILER = 8'hA5;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  typedef logic [6:0] coord_t;

  typedef struct packed {
    logic   is_pixel;
    logic   color;
    logic   live;
    coord_t x_first;
    coord_t x_last;
  } mfl_span_ctl_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/mfl_row_ram.sv */
// ----------------------------------------------------------------------------
// mfl_row_ram
// Simple dual-port row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfl_row_ram #(
  parameter  int DEPTH = 128,
  parameter  int WIDTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/mfl_span_unit.sv */
// ----------------------------------------------------------------------------
// mfl_span_unit
// Row modify unit: applies a pixel write or a column span OR to one row.
// ----------------------------------------------------------------------------
module mfl_span_unit import mfl_pkg::*; (
  input  mfl_span_ctl_t        ctl,
  input  logic [ROW_BITS-1:0]  row_in,
  output logic [ROW_BITS-1:0]  row_out
);

  always_comb begin
    logic old_bit;
    logic in_span;
    logic at_pixel;
    for (int i = 0; i < ROW_BITS; i++) begin
      old_bit  = ctl.live & row_in[i];
      in_span  = (i >= int'(ctl.x_first)) && (i <= int'(ctl.x_last)) && (i < PANEL_WIDTH);
      at_pixel = (i == int'(ctl.x_first)) && (i < PANEL_WIDTH);
      if (ctl.is_pixel) begin
        row_out[i] = at_pixel ? ctl.color : old_bit;
      end else begin
        row_out[i] = old_bit | (in_span & ctl.color);
      end
    end
  end

endmodule

/* hw/rtl/mono_framebuffer_line_flush.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_line_flush
// 1-bit-per-pixel frame store with per-row dirty flags and memory-LCD flush.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command word: pixel, hline,
//   vline, rect, flush row, flush end or clear. Output channel
//   (out_valid/out_ready) delivers panel bytes with frame_start and last.
//   Sequencing: drawing reads then writes each touched row, one row at a
//   time, through the shared row modify unit. A dirty row flush fetches the
//   row, then emits ROW_BYTES+4 words at one per cycle while the receiver is
//   ready. Flush end and clear emit 2 words. in_ready is high only while the
//   sequencer is idle; a finished word sits in the output register while the
//   next command is taken.
//   Clear zeroes the store at once through per-row live bits; no sweep.
//   Reset: the store reads all zero, dirty flags clear, output empty,
//   block ready in the first cycle after reset.
//   Receiver stall: the output register holds its word and the sequencer
//   waits; no word is dropped.
// ----------------------------------------------------------------------------
module mono_framebuffer_line_flush import mfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [6:0] in_x_first,
  input  logic [6:0] in_x_last,
  input  logic [6:0] in_y_first,
  input  logic [6:0] in_y_last,
  input  logic       in_color,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_spi_byte,
  output logic       out_frame_start,
  output logic       out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_FLD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [8:0]       HEIGHT9   = 9'(PANEL_HEIGHT);
  localparam logic [SEQ_W-1:0] IDX_TRAIL = SEQ_W'(ROW_BYTES + 2);
  localparam logic [SEQ_W-1:0] IDX_END   = SEQ_W'(ROW_BYTES + 3);
  localparam logic [SEQ_W-1:0] IDX_ROW   = SEQ_W'(2);

  logic [2:0]              state_r, state_nxt;
  logic [2:0]              mode_r, mode_nxt;
  logic [7:0]              cur_y_r, cur_y_nxt;
  logic [6:0]              y_end_r, y_end_nxt;
  logic [6:0]              y_first_r, y_first_nxt;
  coord_t                  x_first_r, x_first_nxt;
  coord_t                  x_last_r, x_last_nxt;
  logic                    color_r, color_nxt;
  logic [PANEL_HEIGHT-1:0] dirty_r, dirty_nxt;
  logic [PANEL_HEIGHT-1:0] live_r, live_nxt;
  logic [ROW_BITS-1:0]     row_q_r, row_q_nxt;
  logic [SEQ_W-1:0]        idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_byte_r, out_byte_nxt;
  logic                    out_fs_r, out_fs_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_fire;
  logic                    out_load;
  logic                    row_in_panel;
  logic [ROW_AW-1:0]       row_idx;
  logic                    rd_en;
  logic                    wr_en;
  logic [ROW_BITS-1:0]     rd_data;
  logic [ROW_BITS-1:0]     wr_data;
  mfl_span_ctl_t           span_ctl;
  logic [7:0]              gen_byte;
  logic                    gen_fs;
  logic                    gen_last;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid & in_ready;
  assign out_valid       = out_valid_r;
  assign out_spi_byte    = out_byte_r;
  assign out_frame_start = out_fs_r;
  assign out_last        = out_last_r;

  assign row_in_panel = ({1'b0, cur_y_r} < HEIGHT9);
  assign row_idx      = cur_y_r[ROW_AW-1:0];
  assign out_load     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign span_ctl.is_pixel = (mode_r == MODE_PIXEL);
  assign span_ctl.color    = color_r;
  assign span_ctl.live     = live_r[row_idx];
  assign span_ctl.x_first  = x_first_r;
  assign span_ctl.x_last   = x_last_r;

  mfl_row_ram #(
    .DEPTH (PANEL_HEIGHT),
    .WIDTH (ROW_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (row_idx),
    .rd_data (rd_data)
  );

  mfl_span_unit u_span (
    .ctl     (span_ctl),
    .row_in  (rd_data),
    .row_out (wr_data)
  );

  // word generator for the emit sequence
  always_comb begin
    gen_byte = BYTE_ZERO;
    gen_fs   = 1'b0;
    gen_last = 1'b0;
    if (idx_r == '0) begin
      gen_fs = 1'b1;
      case (mode_r)
        MODE_CLEAR:     gen_byte = BYTE_CLEAR;
        MODE_FLUSH_ROW: gen_byte = BYTE_UPDATE;
        default:        gen_byte = BYTE_ZERO;
      endcase
    end else if (mode_r != MODE_FLUSH_ROW) begin
      gen_last = 1'b1;
    end else if (idx_r == SEQ_W'(1)) begin
      gen_byte = bit_rev8({1'b0, y_first_r} + 8'd1);
    end else if (idx_r == IDX_TRAIL) begin
      gen_byte = BYTE_TRAILER;
    end else if (idx_r == IDX_END) begin
      gen_last = 1'b1;
    end else begin
      gen_byte = ~bit_rev8(row_q_r[7:0]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cur_y_nxt     = cur_y_r;
    y_end_nxt     = y_end_r;
    y_first_nxt   = y_first_r;
    x_first_nxt   = x_first_r;
    x_last_nxt    = x_last_r;
    color_nxt     = color_r;
    dirty_nxt     = dirty_r;
    live_nxt      = live_r;
    row_q_nxt     = row_q_r;
    idx_nxt       = idx_r;
    out_byte_nxt  = out_byte_r;
    out_fs_nxt    = out_fs_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt    = in_mode;
          cur_y_nxt   = {1'b0, in_y_first};
          y_first_nxt = in_y_first;
          x_first_nxt = in_x_first;
          x_last_nxt  = (in_mode == MODE_VLINE) ? in_x_first : in_x_last;
          color_nxt   = in_color;
          idx_nxt     = '0;
          y_end_nxt   = ((in_mode == MODE_VLINE) || (in_mode == MODE_RECT)) ?
                        in_y_last : in_y_first;
          case (in_mode)
            MODE_PIXEL, MODE_HLINE, MODE_VLINE, MODE_RECT, MODE_FLUSH_ROW:
              state_nxt = S_RD;
            MODE_FLUSH_END:
              state_nxt = S_EMIT;
            MODE_CLEAR: begin
              live_nxt  = '0;
              state_nxt = S_EMIT;
            end
            default:
              state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (mode_r == MODE_FLUSH_ROW) begin
          if (row_in_panel && dirty_r[row_idx]) begin
            rd_en     = 1'b1;
            state_nxt = S_FLD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (row_in_panel && (cur_y_r <= {1'b0, y_end_r})) begin
          rd_en     = 1'b1;
          state_nxt = S_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WR: begin
        wr_en             = 1'b1;
        live_nxt[row_idx]  = 1'b1;
        dirty_nxt[row_idx] = 1'b1;
        cur_y_nxt         = cur_y_r + 8'd1;
        state_nxt         = S_RD;
      end
      S_FLD: begin
        row_q_nxt          = live_r[row_idx] ? rd_data : '0;
        dirty_nxt[row_idx] = 1'b0;
        state_nxt          = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = gen_byte;
          out_fs_nxt    = gen_fs;
          out_last_nxt  = gen_last;
          idx_nxt       = idx_r + SEQ_W'(1);
          if (idx_r >= IDX_ROW) begin
            row_q_nxt = row_q_r >> 8;
          end
          if (gen_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dirty_r     <= '0;
      live_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dirty_r     <= dirty_nxt;
      live_r      <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    cur_y_r    <= cur_y_nxt;
    y_end_r    <= y_end_nxt;
    y_first_r  <= y_first_nxt;
    x_first_r  <= x_first_nxt;
    x_last_r   <= x_last_nxt;
    color_r    <= color_nxt;
    row_q_r    <= row_q_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_fs_r   <= out_fs_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
